@@ hw/rtl/indexed_array_insert_delete_defines.svh @@
// assertion macros for the indexed array block
`ifndef INDEXED_ARRAY_INSERT_DELETE_DEFINES_SVH
`define INDEXED_ARRAY_INSERT_DELETE_DEFINES_SVH

// same-cycle implication, off during reset
`define IAD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define IAD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/iad_pkg.sv @@
// shared types and codes for the indexed array block
package iad_pkg;

	// request kinds as they arrive on the request word
	localparam logic [2:0] REQ_APPEND = 3'd0;
	localparam logic [2:0] REQ_INSERT = 3'd1;
	localparam logic [2:0] REQ_EDIT   = 3'd2;
	localparam logic [2:0] REQ_DELETE = 3'd3;
	localparam logic [2:0] REQ_GET    = 3'd4;

	// depth of the command queue between front and back
	localparam int Q_DEPTH = 2;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADIDX = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	// work the back end carries out on the store
	typedef enum logic [2:0] {
		OP_NONE   = 3'd0,
		OP_WRITE  = 3'd1,
		OP_INSERT = 3'd2,
		OP_DELETE = 3'd3,
		OP_GET    = 3'd4
	} op_t;

	typedef struct packed {
		op_t                op;
		status_t            status;
		logic               neg;
		logic signed [31:0] value;
		logic [5:0]         item_count;
		logic [5:0]         capacity_now;
	} cmd_t;

endpackage

@@ hw/rtl/iad_if.sv @@
// request and response channel interfaces

interface iad_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         req_type;
	logic [7:0]         position;
	logic signed [31:0] item_value;

	modport source (output valid, output req_type, output position, output item_value,
		input ready);
	modport sink (input valid, input req_type, input position, input item_value,
		output ready);
endinterface

interface iad_rsp_if;
	logic                 valid;
	logic                 ready;
	iad_pkg::status_t     status;
	logic signed [31:0]   read_value;
	logic [5:0]           item_count;
	logic [5:0]           capacity_now;

	modport source (output valid, output status, output read_value, output item_count,
		output capacity_now, input ready);
	modport sink (input valid, input status, input read_value, input item_count,
		input capacity_now, output ready);
endinterface

@@ hw/rtl/indexed_array_insert_delete.sv @@
// Indexed array with append, insert, edit, delete and get on a store of DEPTH
// 32-bit signed entries, with a logical capacity that doubles when an append
// or insert finds the array full (up to DEPTH) and halves after a delete that
// leaves the count at or below half of it. Every request word gives exactly one
// response word with status, read value, item count and capacity. The front end
// checks each request against its own copy of count and capacity, so it settles
// status, count and capacity at once and accepts a new word every cycle while
// the two-entry command queue has room. The back end owns the entry store, a
// memory with one write port and one registered read port, and works one command
// at a time; insert and delete shift the entries between the target index and
// the end of the array, moving one entry per cycle through the store's one read
// and one write port. The response sits in an output register, so the back end
// keeps working on the next command while the response waits. A write on the
// configuration port empties the array and loads the capacity from the written
// value (0 counts as 1, values above DEPTH count as DEPTH); write it only while
// the block is idle.
`include "indexed_array_insert_delete_defines.svh"

module indexed_array_insert_delete #(
	parameter int DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [5:0] cfg_wdata,
	iad_req_if.sink    req,
	iad_rsp_if.source  rsp
);
	localparam int AW = $clog2(DEPTH);
	localparam int CMDW = $bits(iad_pkg::cmd_t);
	localparam int QW = CMDW + 2 * AW;

	// front to queue
	logic              push;
	iad_pkg::cmd_t     f_cmd;
	logic [AW-1:0]     f_addr;
	logic [AW-1:0]     f_last;

	// queue to back
	logic              q_full;
	logic              q_empty;
	logic              pop;
	logic [QW-1:0]     q_dout;
	iad_pkg::cmd_t     q_cmd;
	logic [AW-1:0]     q_addr;
	logic [AW-1:0]     q_last;
	logic              back_idle;

	iad_front #(
		.DEPTH(DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req),
		.q_full   (q_full),
		.push     (push),
		.cmd      (f_cmd),
		.cmd_addr (f_addr),
		.cmd_last (f_last)
	);

	// command word: fields, then target index, then last index
	iad_queue #(
		.W     (QW),
		.QDEPTH(iad_pkg::Q_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   ({f_cmd, f_addr, f_last}),
		.full  (q_full),
		.pop   (pop),
		.dout  (q_dout),
		.empty (q_empty)
	);

	assign q_cmd  = iad_pkg::cmd_t'(q_dout[QW-1 -: CMDW]);
	assign q_addr = q_dout[2*AW-1 -: AW];
	assign q_last = q_dout[AW-1:0];

	iad_back #(
		.DEPTH(DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_cmd  (q_cmd),
		.q_addr (q_addr),
		.q_last (q_last),
		.pop    (pop),
		.idle   (back_idle),
		.rsp    (rsp)
	);

	// a full queue always has something to hand out
	`IAD_ASSERT_NOW(a_queue_fill, clk, arst_n, q_full, !q_empty, "queue full but empty")

	// the back end picks up waiting work right away
	`IAD_ASSERT_NEXT(a_back_pickup, clk, arst_n, back_idle && !q_empty, !back_idle, "back end stalled with work queued")

	// a full status only comes when the store is at its depth
	`IAD_ASSERT_NOW(a_full_count, clk, arst_n, rsp.valid && rsp.status == iad_pkg::ST_FULL, rsp.item_count == 6'(DEPTH), "full status below depth")

	// an empty status only comes with no items
	`IAD_ASSERT_NOW(a_empty_count, clk, arst_n, rsp.valid && rsp.status == iad_pkg::ST_EMPTY, rsp.item_count == 6'd0, "empty status with items")

endmodule

@@ hw/rtl/iad_queue.sv @@
// small command queue between front and back
module iad_queue #(
	parameter int W      = 1,
	parameter int QDEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);
	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int FW = $clog2(QDEPTH + 1);

	logic [W-1:0]  slot_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [FW-1:0] fill_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (fill_q == FW'(QDEPTH));
	assign empty   = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + FW'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - FW'(1);
			end
		end
	end

endmodule

@@ hw/rtl/iad_front.sv @@
// front end: takes requests, checks them against count and capacity, issues commands
module iad_front #(
	parameter int DEPTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [5:0]                    cfg_wdata,
	iad_req_if.sink                       req,
	input  logic                          q_full,
	output logic                          push,
	output iad_pkg::cmd_t                 cmd,
	output logic [$clog2(DEPTH)-1:0]      cmd_addr,
	output logic [$clog2(DEPTH)-1:0]      cmd_last
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > 6) ? CW : 6;
	localparam int PW = (CW > 8) ? CW : 8;

	logic [CW-1:0] count_q;
	logic [CW-1:0] cap_q;
	logic [CW-1:0] cnt_n;
	logic [CW-1:0] cap_n;
	logic [CW-1:0] cnt_dec;
	logic [CW-1:0] cap_dbl;
	logic [CW-1:0] cap_room;
	logic [CW:0]   dbl;
	logic [PW-1:0] pos_w;
	logic [PW-1:0] cnt_w;
	logic          store_full;
	logic          accept;

	// register value 0 means 1, above the store depth means the depth
	function automatic logic [CW-1:0] limit_cap(input logic [5:0] v);
		logic [LW-1:0] ve;
		ve = LW'(v);
		if (v == 6'd0) begin
			return CW'(1);
		end
		if (ve > LW'(DEPTH)) begin
			return CW'(DEPTH);
		end
		return CW'(v);
	endfunction

	assign req.ready  = !q_full;
	assign accept     = req.valid && !q_full;
	assign push       = accept;
	assign store_full = (count_q == CW'(DEPTH));
	assign pos_w      = PW'(req.position);
	assign cnt_w      = PW'(count_q);
	assign cnt_dec    = count_q - CW'(1);
	assign dbl        = {cap_q, 1'b0};
	assign cap_dbl    = (dbl > (CW+1)'(DEPTH)) ? CW'(DEPTH) : dbl[CW-1:0];
	assign cap_room   = (count_q >= cap_q) ? cap_dbl : cap_q;

	always_comb begin
		cmd.op     = iad_pkg::OP_NONE;
		cmd.status = iad_pkg::ST_OK;
		cmd.neg    = 1'b0;
		cmd.value  = req.item_value;
		cnt_n      = count_q;
		cap_n      = cap_q;
		cmd_addr   = AW'(req.position);
		cmd_last   = AW'(count_q);
		unique case (req.req_type)
			iad_pkg::REQ_APPEND: begin
				if (store_full) begin
					cmd.status = iad_pkg::ST_FULL;
				end else begin
					cmd.op   = iad_pkg::OP_WRITE;
					cmd_addr = AW'(count_q);
					cnt_n    = count_q + CW'(1);
					cap_n    = cap_room;
				end
			end
			iad_pkg::REQ_INSERT: begin
				if (pos_w > cnt_w) begin
					cmd.status = iad_pkg::ST_BADIDX;
				end else if (store_full) begin
					cmd.status = iad_pkg::ST_FULL;
				end else begin
					cmd.op = iad_pkg::OP_INSERT;
					cnt_n  = count_q + CW'(1);
					cap_n  = cap_room;
				end
			end
			iad_pkg::REQ_EDIT: begin
				if (pos_w >= cnt_w) begin
					cmd.status = iad_pkg::ST_BADIDX;
				end else begin
					cmd.op = iad_pkg::OP_WRITE;
				end
			end
			iad_pkg::REQ_DELETE: begin
				if (count_q == '0) begin
					cmd.status = iad_pkg::ST_EMPTY;
				end else if (pos_w >= cnt_w) begin
					cmd.status = iad_pkg::ST_BADIDX;
				end else begin
					cmd.op   = iad_pkg::OP_DELETE;
					cmd_last = AW'(cnt_dec);
					cnt_n    = cnt_dec;
					if (cap_q > CW'(1) && cnt_dec <= (cap_q >> 1)) begin
						cap_n = cap_q >> 1;
					end
				end
			end
			iad_pkg::REQ_GET: begin
				if (pos_w >= cnt_w) begin
					cmd.status = iad_pkg::ST_BADIDX;
					cmd.neg    = 1'b1;
				end else begin
					cmd.op = iad_pkg::OP_GET;
				end
			end
			default: begin
				// unused kinds change nothing
			end
		endcase
		cmd.item_count   = 6'(cnt_n);
		cmd.capacity_now = 6'(cap_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= CW'(1);
		end else if (cfg_we) begin
			count_q <= '0;
			cap_q   <= limit_cap(cfg_wdata);
		end else if (accept) begin
			count_q <= cnt_n;
			cap_q   <= cap_n;
		end
	end

endmodule

@@ hw/rtl/iad_back.sv @@
// back end: carries out commands on the entry store and returns response words
module iad_back #(
	parameter int DEPTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_empty,
	input  iad_pkg::cmd_t             q_cmd,
	input  logic [$clog2(DEPTH)-1:0]  q_addr,
	input  logic [$clog2(DEPTH)-1:0]  q_last,
	output logic                      pop,
	output logic                      idle,
	iad_rsp_if.source                 rsp
);
	localparam int AW = $clog2(DEPTH);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_READ = 6'b000010,
		S_UP   = 6'b000100,
		S_PUT  = 6'b001000,
		S_DOWN = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t             state_q;
	state_t             state_d;
	iad_pkg::cmd_t      cmd_q;
	logic [AW-1:0]      addr_q;
	logic [AW-1:0]      last_q;
	logic [AW-1:0]      ptr_q;
	logic [AW-1:0]      ptr_d;
	logic [31:0]        entries [DEPTH];
	logic [31:0]        rd_data_q;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [31:0]        mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;
	logic               load_out;
	logic               out_valid_q;
	iad_pkg::status_t   out_status_q;
	logic signed [31:0] out_value_q;
	logic [5:0]         out_count_q;
	logic [5:0]         out_cap_q;

	assign idle = (state_q == S_IDLE);

	always_comb begin
		state_d   = state_q;
		ptr_d     = ptr_q;
		pop       = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = rd_data_q;
		mem_re    = 1'b0;
		mem_raddr = ptr_q;
		load_out  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_d = S_FIN;
					case (q_cmd.op)
						iad_pkg::OP_WRITE: begin
							mem_we    = 1'b1;
							mem_waddr = q_addr;
							mem_wdata = q_cmd.value;
						end
						iad_pkg::OP_GET: begin
							mem_re    = 1'b1;
							mem_raddr = q_addr;
							state_d   = S_READ;
						end
						iad_pkg::OP_INSERT: begin
							if (q_last == q_addr) begin
								mem_we    = 1'b1;
								mem_waddr = q_addr;
								mem_wdata = q_cmd.value;
							end else begin
								// move entries up, top first
								mem_re    = 1'b1;
								mem_raddr = q_last - AW'(1);
								ptr_d     = q_last;
								state_d   = S_UP;
							end
						end
						iad_pkg::OP_DELETE: begin
							if (q_last != q_addr) begin
								// move entries down, lowest first
								mem_re    = 1'b1;
								mem_raddr = q_addr + AW'(1);
								ptr_d     = q_addr;
								state_d   = S_DOWN;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_READ: begin
				state_d = S_FIN;
			end
			S_UP: begin
				mem_we = 1'b1;
				if (ptr_q == addr_q + AW'(1)) begin
					state_d = S_PUT;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = ptr_q - AW'(2);
					ptr_d     = ptr_q - AW'(1);
				end
			end
			S_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = addr_q;
				mem_wdata = cmd_q.value;
				state_d   = S_FIN;
			end
			S_DOWN: begin
				mem_we = 1'b1;
				if (ptr_q + AW'(1) == last_q) begin
					state_d = S_FIN;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = ptr_q + AW'(2);
					ptr_d     = ptr_q + AW'(1);
				end
			end
			S_FIN: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// entry store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			entries[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= entries[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q  <= q_cmd;
			addr_q <= q_addr;
			last_q <= q_last;
		end
		ptr_q <= ptr_d;
		if (load_out) begin
			out_status_q <= cmd_q.status;
			out_count_q  <= cmd_q.item_count;
			out_cap_q    <= cmd_q.capacity_now;
			if (cmd_q.op == iad_pkg::OP_GET) begin
				out_value_q <= rd_data_q;
			end else begin
				out_value_q <= cmd_q.neg ? '1 : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.read_value   = out_value_q;
	assign rsp.item_count   = out_count_q;
	assign rsp.capacity_now = out_cap_q;

endmodule

@@ dv/indexed_array_insert_delete_tb.sv @@
// self-checking testbench for the indexed array block with its own shadow copy of the array
`timescale 1ns / 100ps

localparam int ARRAY_DEPTH = 32;

// request kinds the block must ignore
localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

typedef struct {
	iad_pkg::status_t   status;
	logic signed [31:0] read_value;
	logic [5:0]         item_count;
	logic [5:0]         capacity_now;
} array_reply_t;

// shadow of the array contents, count and capacity, plus the replies still owed
class array_shadow;
	logic signed [31:0] entries [ARRAY_DEPTH];
	int unsigned        count;
	int unsigned        capacity;
	array_reply_t       pending [$];
	int                 errors;

	function new();
		errors = 0;
		load_capacity(6'd1);
	endfunction

	// register write empties the array and restarts the capacity
	function void load_capacity(logic [5:0] cap_reg);
		count = 0;
		if (cap_reg == 0)
			capacity = 1;
		else if (cap_reg > ARRAY_DEPTH)
			capacity = ARRAY_DEPTH;
		else
			capacity = 32'(cap_reg);
	endfunction

	// double when full, refuse at the store limit
	function bit make_room();
		if (count >= ARRAY_DEPTH)
			return 1'b0;
		if (count >= capacity)
			capacity = (capacity * 2 > ARRAY_DEPTH) ? ARRAY_DEPTH : capacity * 2;
		return 1'b1;
	endfunction

	function void note_request(logic [2:0] kind, logic [7:0] pos, logic signed [31:0] val);
		array_reply_t reply;
		reply.status = iad_pkg::ST_OK;
		reply.read_value = 32'sd0;
		case (kind)
		iad_pkg::REQ_APPEND: begin
			if (!make_room())
				reply.status = iad_pkg::ST_FULL;
			else begin
				entries[count] = val;
				count++;
			end
		end
		iad_pkg::REQ_INSERT: begin
			if (32'(pos) > count)
				reply.status = iad_pkg::ST_BADIDX;
			else if (!make_room())
				reply.status = iad_pkg::ST_FULL;
			else begin
				for (int i = int'(count); i > int'(pos); i--)
					entries[i] = entries[i - 1];
				entries[pos] = val;
				count++;
			end
		end
		iad_pkg::REQ_EDIT: begin
			if (32'(pos) >= count)
				reply.status = iad_pkg::ST_BADIDX;
			else
				entries[pos] = val;
		end
		iad_pkg::REQ_DELETE: begin
			if (count == 0)
				reply.status = iad_pkg::ST_EMPTY;
			else if (32'(pos) >= count)
				reply.status = iad_pkg::ST_BADIDX;
			else begin
				for (int i = int'(pos); i + 1 < int'(count); i++)
					entries[i] = entries[i + 1];
				count--;
				if (capacity > 1 && count <= capacity / 2)
					capacity = capacity / 2;
			end
		end
		iad_pkg::REQ_GET: begin
			if (32'(pos) >= count) begin
				reply.status = iad_pkg::ST_BADIDX;
				reply.read_value = -32'sd1;
			end else
				reply.read_value = entries[pos];
		end
		default: ;
		endcase
		reply.item_count = 6'(count);
		reply.capacity_now = 6'(capacity);
		pending.push_back(reply);
	endfunction

	function void compare_field(string label, logic signed [32:0] want, logic signed [32:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, label, want, got);
			errors++;
		end
	endfunction

	function void check_response(iad_pkg::status_t st, logic signed [31:0] rd, logic [5:0] cnt,
		logic [5:0] cap);
		array_reply_t want;
		if (pending.size() == 0) begin
			$display("%0t: expected no word, got status %0d value %0d count %0d capacity %0d",
				$time, st, rd, cnt, cap);
			errors++;
			return;
		end
		want = pending.pop_front();
		compare_field("status", 33'(want.status), 33'(st));
		compare_field("read_value", 33'(want.read_value), 33'(rd));
		compare_field("item_count", 33'(want.item_count), 33'(cnt));
		compare_field("capacity_now", 33'(want.capacity_now), 33'(cap));
	endfunction
endclass

module indexed_array_insert_delete_tb;

	// cycles to wait for outstanding words before giving up on them
	localparam int DRAIN_LIMIT = 20000;
	// receiver hold-off long enough to back up the command queue
	localparam int LONG_HOLD = 80;
	localparam int PHASE_ITEMS = 150;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [5:0] cfg_wdata;

	iad_req_if req();
	iad_rsp_if rsp();

	array_shadow shadow = new();

	// idle percentages for the current phase
	int tx_idle_pct;
	int rx_stall_pct;
	// raised by the sender, taken by the receiver to start a long hold-off
	bit long_hold_req;

	indexed_array_insert_delete #(
		.DEPTH(ARRAY_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req),
		.rsp(rsp)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// offer one request word, with random gaps before it, and log it once taken
	task automatic drive_word(logic [2:0] kind, logic [7:0] pos, logic signed [31:0] val);
		while ($urandom_range(99) < tx_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= kind;
		req.position <= pos;
		req.item_value <= val;
		do
			@(posedge clk);
		while (!req.ready);
		shadow.note_request(kind, pos, val);
	endtask

	// stop offering and let every outstanding word come back
	task automatic drain_responses();
		int waited;
		waited = 0;
		req.valid <= 1'b0;
		while (shadow.pending.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
	endtask

	// capacity register write, only with the block drained
	task automatic write_initial_capacity(logic [5:0] cap_reg);
		drain_responses();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= cap_reg;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow.load_capacity(cap_reg);
	endtask

	// random request shaped by whether the array should be growing or shrinking
	function automatic void pick_request(bit grow, output logic [2:0] kind,
		output logic [7:0] pos, output logic signed [31:0] val);
		int unsigned roll;
		int unsigned n;
		roll = $urandom_range(99);
		n = shadow.count;
		case ($urandom_range(15))
		0: val = 32'sh7fffffff;
		1: val = 32'sh80000000;
		2: val = 32'sd0;
		3: val = -32'sd1;
		default: val = $urandom;
		endcase
		if (roll < 4) begin
			// noise: any kind, any index
			kind = 3'($urandom_range(7));
			pos = 8'($urandom_range(255));
		end else begin
			if (grow)
				kind = roll < 40 ? iad_pkg::REQ_APPEND : roll < 70 ? iad_pkg::REQ_INSERT :
					roll < 80 ? iad_pkg::REQ_EDIT : roll < 90 ? iad_pkg::REQ_GET :
					iad_pkg::REQ_DELETE;
			else
				kind = roll < 45 ? iad_pkg::REQ_DELETE : roll < 65 ? iad_pkg::REQ_GET :
					roll < 75 ? iad_pkg::REQ_EDIT : roll < 88 ? iad_pkg::REQ_APPEND :
					iad_pkg::REQ_INSERT;
			// mostly in range, now and then just past the end
			if ($urandom_range(9) == 0)
				pos = (kind == iad_pkg::REQ_INSERT) ? 8'(n + 1) : 8'(n);
			else if (kind == iad_pkg::REQ_INSERT)
				pos = 8'($urandom_range(n));
			else
				pos = (n == 0) ? 8'd0 : 8'($urandom_range(n - 1));
		end
	endfunction

	// response side: check each taken word, then pick the next ready
	initial begin : response_sink
		int hold_left;
		hold_left = 0;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready)
				shadow.check_response(rsp.status, rsp.read_value, rsp.item_count,
					rsp.capacity_now);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else
				rsp.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	initial begin : stimulus
		int         tx_pct [6];
		int         rx_pct [6];
		logic [5:0] cap_values [6];
		logic [2:0] kind;
		logic [7:0] pos;
		logic signed [31:0] val;
		int         done;
		bit         grow;
		bit         held;

		// phases: quiet, sender gaps, receiver stalls, both, quiet with pressure, both
		tx_pct = '{0, 59, 0, 24, 0, 24};
		rx_pct = '{0, 0, 59, 24, 0, 24};
		// capacity settings per phase, extremes among them
		cap_values = '{6'd0, 6'd32, 6'd63, 6'd5, 6'd17, 6'd1};

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 6'd0;
		req.valid = 1'b0;
		req.req_type = iad_pkg::REQ_APPEND;
		req.position = 8'd0;
		req.item_value = 32'sd0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		long_hold_req = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset capacity of one
		// reads, edits and deletes on an empty array; delete reports empty first
		drive_word(iad_pkg::REQ_GET, 8'd0, 32'sd0);
		drive_word(iad_pkg::REQ_EDIT, 8'd0, 32'sd1);
		drive_word(iad_pkg::REQ_DELETE, 8'd255, 32'sd0);
		// ignored kinds
		drive_word(REQ_SPARE_FIRST, 8'd3, 32'sh12345678);
		drive_word(REQ_SPARE_LAST, 8'd255, -32'sd1);
		// fill with extreme values, growing the capacity 1 -> 2 -> 4
		drive_word(iad_pkg::REQ_APPEND, 8'd0, 32'sh7fffffff);
		drive_word(iad_pkg::REQ_APPEND, 8'd0, 32'sh80000000);
		drive_word(iad_pkg::REQ_INSERT, 8'd0, 32'sd0);
		// insert at the very end is legal, one past it is not
		drive_word(iad_pkg::REQ_INSERT, 8'd3, -32'sd1);
		drive_word(iad_pkg::REQ_INSERT, 8'd5, 32'sd7);
		drive_word(iad_pkg::REQ_EDIT, 8'd1, 32'sh55555555);
		drive_word(iad_pkg::REQ_EDIT, 8'd4, 32'sh2aaaaaaa);
		drive_word(iad_pkg::REQ_GET, 8'd0, 32'sd0);
		drive_word(iad_pkg::REQ_GET, 8'd1, 32'sd0);
		drive_word(iad_pkg::REQ_GET, 8'd2, 32'sd0);
		drive_word(iad_pkg::REQ_GET, 8'd3, 32'sd0);
		drive_word(iad_pkg::REQ_GET, 8'd4, 32'sd0);
		drive_word(iad_pkg::REQ_GET, 8'd255, 32'sd0);
		// shrink: delete last and first, capacity halves on the way down
		drive_word(iad_pkg::REQ_DELETE, 8'd3, 32'sd0);
		drive_word(iad_pkg::REQ_DELETE, 8'd0, 32'sd0);
		drive_word(iad_pkg::REQ_DELETE, 8'd2, 32'sd0);
		drive_word(iad_pkg::REQ_DELETE, 8'd0, 32'sd0);
		drive_word(iad_pkg::REQ_GET, 8'd0, 32'sd0);
		drive_word(iad_pkg::REQ_DELETE, 8'd0, 32'sd0);

		// random part, one capacity setting per phase
		grow = 1'b1;
		for (int p = 0; p < 6; p++) begin
			write_initial_capacity(cap_values[p]);
			tx_idle_pct = tx_pct[p];
			rx_stall_pct = rx_pct[p];
			grow = 1'b1;
			held = 1'b0;
			done = 0;
			while (done < PHASE_ITEMS) begin
				// swing between filling to the store limit and draining to empty
				if (shadow.count == ARRAY_DEPTH && $urandom_range(5) == 0)
					grow = 1'b0;
				else if (shadow.count == 0 && $urandom_range(3) == 0)
					grow = 1'b1;
				pick_request(grow, kind, pos, val);
				drive_word(kind, pos, val);
				if (kind <= iad_pkg::REQ_GET)
					done++;
				// pressure phase: long receiver hold-off, later a full sender pause
				if (p == 4 && done == 40 && !held) begin
					held = 1'b1;
					long_hold_req = 1'b1;
				end
				if (p == 4 && done == 100 && kind <= iad_pkg::REQ_GET)
					drain_responses();
			end
		end

		drain_responses();
		repeat (8) @(posedge clk);
		if (shadow.pending.size() != 0) begin
			$display("%0t: expected %0d more words, got none", $time, shadow.pending.size());
			shadow.errors++;
		end
		if (shadow.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin : watchdog
		#20000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
